// ----- hdl/matrix_row_ops_and_matvec_macros.svh -----
// Assertion macros for the matrix row-ops / mat-vec block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MATRIX_ROW_OPS_AND_MATVEC_MACROS_SVH
`define MATRIX_ROW_OPS_AND_MATVEC_MACROS_SVH
`ifndef SYNTHESIS
`define MRV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MRV_NEVER(name, cond, msg) \
  `MRV_ASSERT(name, !(cond), msg)
`else
`define MRV_ASSERT(name, prop, msg)
`define MRV_NEVER(name, cond, msg)
`endif
`endif

// ----- hdl/mrv_pkg.sv -----
// Package for the matrix row-ops / mat-vec block: item types, codes, defaults.
// No dependencies.
package mrv_pkg;

  localparam int MAX_ROWS_DEF      = 16;
  localparam int MAX_COLUMNS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNT_W           = 5;
  localparam int COUNT_RESET       = 16;

  localparam logic [3:0] KIND_WRITE     = 4'd0;
  localparam logic [3:0] KIND_READ      = 4'd1;
  localparam logic [3:0] KIND_FILL      = 4'd2;
  localparam logic [3:0] KIND_SWAP      = 4'd3;
  localparam logic [3:0] KIND_SCALE_ROW = 4'd4;
  localparam logic [3:0] KIND_ADD_ROW   = 4'd5;
  localparam logic [3:0] KIND_SCALE_ALL = 4'd6;
  localparam logic [3:0] KIND_LOAD_VEC  = 4'd7;
  localparam logic [3:0] KIND_MULTIPLY  = 4'd8;

  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         row_a;
    logic [3:0]         row_b;
    logic [3:0]         column;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [3:0]         row_index;
    logic               error;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

// ----- hdl/matrix_row_ops_and_matvec.sv -----
// Top level: matrix store with row operations and mat-vec multiply.
// Uses mrv_pkg, mrv_mem, mrv_mac and the assertion macro header.
//
//   channel  direction  handshake             item
//   in       in         in_valid_i/in_stall_o  mrv_pkg::in_item_t
//   out      out        out_valid_o/out_stall_i mrv_pkg::out_item_t
//   cfg      in         cfg_valid_i/cfg_ready_o index + 5-bit count
//
// Write, fill, load, errors and unknown kinds go straight to the result.
// Read: memory read, then result. Row ops walk each entry (memory read,
// multiply, write-back through the one shared multiplier); swap writes
// both rows back per entry. Multiply and scale-all walk every row; multiply
// emits each row sum. No clearing pass after reset; a stalled output holds
// the sequencer in the emit step, and a new item waits until it is idle.
`include "matrix_row_ops_and_matvec_macros.svh"
module matrix_row_ops_and_matvec #(
  parameter int MAX_ROWS      = mrv_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS   = mrv_pkg::MAX_COLUMNS_DEF,
  parameter int FRACTION_BITS = mrv_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrv_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrv_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VDEPTH = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;
  localparam int VAW   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int CW    = mrv_pkg::COUNT_W;
  localparam logic signed [32:0] ONE = 33'sd1 <<< FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_WAIT, ST_WB, ST_SWAP_B, ST_EMIT
  } state_e;

  state_e             state_q;
  logic [3:0]         kind_q;
  logic [3:0]         src_q, dst_q;
  logic [CW-1:0]      r_q, c_q;
  logic signed [32:0] scalar_q;
  logic signed [31:0] res_data_q;
  logic               res_err_q;
  logic [CW-1:0]      row_cnt_q, col_cnt_q;
  logic signed [31:0] vec_q [VDEPTH];
  mrv_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic [CW-1:0]      rows_e, cols_e;
  logic               accept, out_load, last_col, last_row;
  logic               ra_ok, rb_ok, col_ok;
  logic               mem_fill, mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic signed [31:0] wdata, rdata_a, rdata_b;
  logic signed [32:0] mac_a;
  logic signed [31:0] mac_addend, mac_wb, mac_sum;
  mrv_pkg::mac_ctrl_t mac_ctrl;

  function automatic logic [AW-1:0] ent_addr(logic [3:0] r, logic [3:0] c);
    int a;
    a = int'(r) * MAX_COLUMNS + int'(c);
    return AW'(a);
  endfunction

  function automatic logic [CW-1:0] eff_count(logic [CW-1:0] raw, int lim);
    logic [CW-1:0] e;
    if (raw == '0) begin
      e = CW'(1);
    end else if (int'(raw) > lim) begin
      e = CW'(lim);
    end else begin
      e = raw;
    end
    return e;
  endfunction

  assign rows_e   = eff_count(row_cnt_q, MAX_ROWS);
  assign cols_e   = eff_count(col_cnt_q, MAX_COLUMNS);
  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_col = (c_q + CW'(1)) == cols_e;
  assign last_row = (r_q + CW'(1)) == rows_e;
  assign ra_ok    = {1'b0, in_item_i.row_a} < rows_e;
  assign rb_ok    = {1'b0, in_item_i.row_b} < rows_e;
  assign col_ok   = {1'b0, in_item_i.column} < cols_e;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    mem_fill = accept && (in_item_i.kind == mrv_pkg::KIND_FILL);
    mem_we   = 1'b0;
    waddr    = ent_addr(dst_q, c_q[3:0]);
    wdata    = mac_wb;
    if (accept && in_item_i.kind == mrv_pkg::KIND_WRITE && ra_ok && col_ok) begin
      mem_we = 1'b1;
      waddr  = ent_addr(in_item_i.row_a, in_item_i.column);
      wdata  = in_item_i.value;
    end else if (state_q == ST_WAIT && kind_q == mrv_pkg::KIND_SWAP) begin
      mem_we = 1'b1;
      wdata  = rdata_a;
    end else if (state_q == ST_SWAP_B) begin
      mem_we = 1'b1;
      waddr  = ent_addr(src_q, c_q[3:0]);
      wdata  = rdata_b;
    end else if (state_q == ST_WB && kind_q != mrv_pkg::KIND_MULTIPLY) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re  = (state_q == ST_RD);
  assign raddr_a = ent_addr(src_q, c_q[3:0]);
  assign raddr_b = ent_addr(dst_q, c_q[3:0]);

  assign mac_a      = (kind_q == mrv_pkg::KIND_MULTIPLY) ? 33'(vec_q[c_q[VAW-1:0]]) : scalar_q;
  assign mac_addend = (kind_q == mrv_pkg::KIND_ADD_ROW) ? rdata_b : 32'sd0;
  assign mac_ctrl.mul_en  = (state_q == ST_WAIT);
  assign mac_ctrl.acc_clr = (state_q == ST_IDLE) || out_load;
  assign mac_ctrl.acc_en  = (state_q == ST_WB) && (kind_q == mrv_pkg::KIND_MULTIPLY);

  mrv_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_i       (mem_fill),
    .fill_value_i (in_item_i.value),
    .we_i         (mem_we),
    .waddr_i      (waddr),
    .wdata_i      (wdata),
    .re_i         (mem_re),
    .raddr_a_i    (raddr_a),
    .raddr_b_i    (raddr_b),
    .rdata_a_o    (rdata_a),
    .rdata_b_o    (rdata_b)
  );

  mrv_mac #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .a_i      (mac_a),
    .b_i      (rdata_a),
    .addend_i (mac_addend),
    .wb_o     (mac_wb),
    .sum_o    (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= CW'(mrv_pkg::COUNT_RESET);
      col_cnt_q <= CW'(mrv_pkg::COUNT_RESET);
      for (int i = 0; i < VDEPTH; i++) begin
        vec_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mrv_pkg::CFG_ROW_COUNT:    row_cnt_q <= cfg_data_i;
          mrv_pkg::CFG_COLUMN_COUNT: col_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && in_item_i.kind == mrv_pkg::KIND_LOAD_VEC && col_ok) begin
        vec_q[in_item_i.column[VAW-1:0]] <= in_item_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= mrv_pkg::KIND_WRITE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      scalar_q    <= '0;
      res_data_q  <= '0;
      res_err_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q     <= in_item_i.kind;
            src_q      <= in_item_i.row_a;
            dst_q      <= in_item_i.row_a;
            r_q        <= '0;
            c_q        <= '0;
            scalar_q   <= 33'(in_item_i.value);
            res_data_q <= '0;
            res_err_q  <= 1'b0;
            state_q    <= ST_EMIT;
            case (in_item_i.kind)
              mrv_pkg::KIND_WRITE: res_err_q <= !(ra_ok && col_ok);
              mrv_pkg::KIND_READ: begin
                if (ra_ok && col_ok) begin
                  c_q     <= {1'b0, in_item_i.column};
                  state_q <= ST_RD;
                end else begin
                  res_err_q <= 1'b1;
                end
              end
              mrv_pkg::KIND_SWAP: begin
                dst_q <= in_item_i.row_b;
                if (!(ra_ok && rb_ok)) begin
                  res_err_q <= 1'b1;
                end else if (in_item_i.row_a != in_item_i.row_b) begin
                  state_q <= ST_RD;
                end
              end
              mrv_pkg::KIND_SCALE_ROW: begin
                if (ra_ok) begin
                  state_q <= ST_RD;
                end else begin
                  res_err_q <= 1'b1;
                end
              end
              mrv_pkg::KIND_ADD_ROW: begin
                dst_q <= in_item_i.row_b;
                if (!(ra_ok && rb_ok)) begin
                  res_err_q <= 1'b1;
                end else if (in_item_i.value != 32'sd0) begin
                  state_q <= ST_RD;
                  if (in_item_i.row_a == in_item_i.row_b) begin
                    kind_q   <= mrv_pkg::KIND_SCALE_ROW;
                    scalar_q <= 33'(in_item_i.value) + ONE;
                  end
                end
              end
              mrv_pkg::KIND_SCALE_ALL, mrv_pkg::KIND_MULTIPLY: begin
                src_q   <= '0;
                dst_q   <= '0;
                state_q <= ST_RD;
              end
              mrv_pkg::KIND_LOAD_VEC: res_err_q <= !col_ok;
              default: ;
            endcase
          end
        end
        ST_RD: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (kind_q == mrv_pkg::KIND_READ) begin
            res_data_q <= rdata_a;
            state_q    <= ST_EMIT;
          end else if (kind_q == mrv_pkg::KIND_SWAP) begin
            state_q <= ST_SWAP_B;
          end else begin
            state_q <= ST_WB;
          end
        end
        ST_SWAP_B: begin
          if (last_col) begin
            state_q <= ST_EMIT;
          end else begin
            c_q     <= c_q + CW'(1);
            state_q <= ST_RD;
          end
        end
        ST_WB: begin
          if (!last_col) begin
            c_q     <= c_q + CW'(1);
            state_q <= ST_RD;
          end else if (kind_q == mrv_pkg::KIND_SCALE_ALL && !last_row) begin
            c_q     <= '0;
            r_q     <= r_q + CW'(1);
            src_q   <= src_q + 4'd1;
            dst_q   <= dst_q + 4'd1;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            if (kind_q == mrv_pkg::KIND_MULTIPLY) begin
              out_q.data      <= mac_sum;
              out_q.row_index <= r_q[3:0];
              out_q.error     <= 1'b0;
              out_q.last      <= last_row;
            end else begin
              out_q.data      <= res_err_q ? 32'sd0 : res_data_q;
              out_q.row_index <= '0;
              out_q.error     <= res_err_q;
              out_q.last      <= 1'b1;
            end
            if (kind_q == mrv_pkg::KIND_MULTIPLY && !last_row) begin
              c_q     <= '0;
              r_q     <= r_q + CW'(1);
              src_q   <= src_q + 4'd1;
              state_q <= ST_RD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `MRV_ASSERT(a_accept_busy, accept |=> state_q != ST_IDLE, "item accepted but sequencer idle")
  `MRV_NEVER(a_err_form, out_valid_q && out_q.error && (!out_q.last || out_q.data != 0), "bad error item")
  `MRV_ASSERT(a_col_range, state_q == ST_RD |-> c_q < cols_e, "column counter past columns in use")

endmodule

// ----- hdl/mrv_mem.sv -----
// Matrix entry memory: one write port, two registered read ports.
// Per-entry valid bits; an unwritten entry reads as the last fill value.
module mrv_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fill_i,
  input  logic signed [31:0]   fill_value_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_a_i,
  input  logic [AW-1:0]        raddr_b_i,
  output logic signed [31:0]   rdata_a_o,
  output logic signed [31:0]   rdata_b_o
);

  logic signed [31:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic signed [31:0] fill_q;
  logic signed [31:0] rd_a_q, rd_b_q;
  logic               vld_a_q, vld_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (fill_i) begin
        valid_q <= '0;
        fill_q  <= fill_value_i;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_a_q <= valid_q[raddr_a_i];
        vld_b_q <= valid_q[raddr_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = vld_a_q ? rd_a_q : fill_q;
  assign rdata_b_o = vld_b_q ? rd_b_q : fill_q;

endmodule

// ----- hdl/mrv_mac.sv -----
// Shared multiply-accumulate unit: registered signed product, floor shift,
// saturating write-back value and a wide row accumulator. Uses mrv_pkg.
module mrv_mac #(
  parameter int MAX_COLUMNS   = mrv_pkg::MAX_COLUMNS_DEF,
  parameter int FRACTION_BITS = mrv_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  mrv_pkg::mac_ctrl_t  ctrl_i,
  input  logic signed [32:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic signed [31:0]  addend_i,
  output logic signed [31:0]  wb_o,
  output logic signed [31:0]  sum_o
);

  localparam int PW    = 65;
  localparam int ACC_W = PW + $clog2(MAX_COLUMNS + 1) + 1;

  logic signed [PW-1:0]    prod_q;
  logic signed [PW-1:0]    shifted;
  logic signed [PW:0]      wsum;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PW'(a_i) * PW'(b_i);
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(shifted);
    end
  end

  assign shifted = prod_q >>> FRACTION_BITS;
  assign wsum    = (PW + 1)'(shifted) + (PW + 1)'(addend_i);

  always_comb begin
    if (wsum > (PW + 1)'(64'sd2147483647)) begin
      wb_o = 32'sh7fffffff;
    end else if (wsum < -(PW + 1)'(64'sd2147483648)) begin
      wb_o = 32'sh80000000;
    end else begin
      wb_o = wsum[31:0];
    end
    if (acc_q > ACC_W'(64'sd2147483647)) begin
      sum_o = 32'sh7fffffff;
    end else if (acc_q < -ACC_W'(64'sd2147483648)) begin
      sum_o = 32'sh80000000;
    end else begin
      sum_o = acc_q[31:0];
    end
  end

endmodule

// ----- test/tb_matrix_row_ops_and_matvec.sv -----
// Testbench for matrix_row_ops_and_matvec: directed table, then random items of every kind.
// A local predictor of the matrix and vector stores checks every result; needs mrv_pkg.
module tb_matrix_row_ops_and_matvec;

  localparam int NR = mrv_pkg::MAX_ROWS_DEF;
  localparam int NC = mrv_pkg::MAX_COLUMNS_DEF;
  localparam int FB = mrv_pkg::FRACTION_BITS_DEF;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [4:0] cfg_data_i;
  mrv_pkg::in_item_t in_item_i;
  mrv_pkg::out_item_t out_item_o;

  matrix_row_ops_and_matvec dut (.*);

  logic signed [31:0] mat_q [NR*NC];
  logic signed [31:0] vec_q [NC];
  logic [4:0] rows_raw, cols_raw;
  mrv_pkg::out_item_t pending_results [$];
  int errors;
  bit hold_off;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic void queue_result(mrv_pkg::out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    return 64'(p >>> FB);
  endfunction

  function automatic logic signed [31:0] sat(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int eff(logic [4:0] raw, int mx);
    if (raw == 0) return 1;
    return (raw > mx) ? mx : int'(raw);
  endfunction

  function automatic mrv_pkg::out_item_t mk(logic signed [31:0] d, logic [3:0] r, logic e,
                                            logic l);
    mrv_pkg::out_item_t o;
    o.data = d; o.row_index = r; o.error = e; o.last = l;
    return o;
  endfunction

  task automatic scale_row_q(int r, int cols, logic signed [63:0] s);
    for (int c = 0; c < cols; c++) mat_q[r*NC+c] = sat(fx_mul(mat_q[r*NC+c], s));
  endtask

  task automatic predict_matrix_op(input mrv_pkg::in_item_t it);
    int rows, cols;
    logic signed [63:0] v, sum;
    rows = eff(rows_raw, NR);
    cols = eff(cols_raw, NC);
    v = it.value;
    case (it.kind)
      mrv_pkg::KIND_WRITE, mrv_pkg::KIND_READ: begin
        if (it.row_a >= rows || it.column >= cols) queue_result(mk(0, 0, 1, 1));
        else if (it.kind == mrv_pkg::KIND_WRITE) begin
          mat_q[it.row_a*NC+it.column] = it.value;
          queue_result(mk(0, 0, 0, 1));
        end else queue_result(mk(mat_q[it.row_a*NC+it.column], 0, 0, 1));
      end
      mrv_pkg::KIND_FILL: begin
        foreach (mat_q[i]) mat_q[i] = it.value;
        queue_result(mk(0, 0, 0, 1));
      end
      mrv_pkg::KIND_SWAP: begin
        if (it.row_a >= rows || it.row_b >= rows) queue_result(mk(0, 0, 1, 1));
        else begin
          for (int c = 0; c < cols; c++) begin
            logic signed [31:0] t;
            t = mat_q[it.row_a*NC+c];
            mat_q[it.row_a*NC+c] = mat_q[it.row_b*NC+c];
            mat_q[it.row_b*NC+c] = t;
          end
          queue_result(mk(0, 0, 0, 1));
        end
      end
      mrv_pkg::KIND_SCALE_ROW: begin
        if (it.row_a >= rows) queue_result(mk(0, 0, 1, 1));
        else begin
          scale_row_q(it.row_a, cols, v);
          queue_result(mk(0, 0, 0, 1));
        end
      end
      mrv_pkg::KIND_ADD_ROW: begin
        if (it.row_a >= rows || it.row_b >= rows) queue_result(mk(0, 0, 1, 1));
        else begin
          if (v != 0) begin
            if (it.row_a == it.row_b) scale_row_q(it.row_a, cols, v + (64'sd1 <<< FB));
            else
              for (int c = 0; c < cols; c++)
                mat_q[it.row_b*NC+c] = sat(64'(mat_q[it.row_b*NC+c])
                                           + fx_mul(v, mat_q[it.row_a*NC+c]));
          end
          queue_result(mk(0, 0, 0, 1));
        end
      end
      mrv_pkg::KIND_SCALE_ALL: begin
        for (int r = 0; r < rows; r++) scale_row_q(r, cols, v);
        queue_result(mk(0, 0, 0, 1));
      end
      mrv_pkg::KIND_LOAD_VEC: begin
        if (it.column >= cols) queue_result(mk(0, 0, 1, 1));
        else begin
          vec_q[it.column] = it.value;
          queue_result(mk(0, 0, 0, 1));
        end
      end
      mrv_pkg::KIND_MULTIPLY: begin
        for (int r = 0; r < rows; r++) begin
          sum = 0;
          for (int c = 0; c < cols; c++) sum += fx_mul(mat_q[r*NC+c], vec_q[c]);
          queue_result(mk(sat(sum), 4'(r), 0, (r + 1 == rows)));
        end
      end
      default: queue_result(mk(0, 0, 0, 1));
    endcase
  endtask

  // output side: random stall, plus one long hold-off
  initial begin
    int w;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      out_stall_i <= (w != 0);
      if (w != 0) repeat (w - 1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    mrv_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) report("result with nothing expected");
      else begin
        exp_r = pending_results.pop_front();
        if (out_item_o.data !== exp_r.data)
          report($sformatf("data %h exp %h", out_item_o.data, exp_r.data));
        if (out_item_o.row_index !== exp_r.row_index)
          report($sformatf("row_index %0d exp %0d", out_item_o.row_index, exp_r.row_index));
        if (out_item_o.error !== exp_r.error)
          report($sformatf("error %b exp %b", out_item_o.error, exp_r.error));
        if (out_item_o.last !== exp_r.last)
          report($sformatf("last %b exp %b", out_item_o.last, exp_r.last));
      end
    end
  end

  // valid stays up after an accept until the next item or an idle gap replaces it
  task automatic send(input mrv_pkg::in_item_t it);
    int w;
    w = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_matrix_op(it);
  endtask

  task automatic set_count(input logic idx, input logic [4:0] v);
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == mrv_pkg::CFG_ROW_COUNT) rows_raw = v; else cols_raw = v;
  endtask

  function automatic mrv_pkg::in_item_t item(logic [3:0] k, logic [3:0] a, logic [3:0] b,
                                             logic [3:0] c, logic signed [31:0] v);
    mrv_pkg::in_item_t it;
    it.kind = k; it.row_a = a; it.row_b = b; it.column = c; it.value = v;
    return it;
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      3: return 32'sh00010000;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic mrv_pkg::in_item_t rnd_item(int rows, int cols);
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) return item(mrv_pkg::KIND_WRITE, 4'($urandom_range(0, rows)), 0,
                             4'($urandom_range(0, cols)), rnd_val());
    if (k < 35) return item(mrv_pkg::KIND_LOAD_VEC, 4'($urandom), 4'($urandom),
                             4'($urandom_range(0, cols)), rnd_val());
    if (k < 45) return item(mrv_pkg::KIND_READ, 4'($urandom_range(0, rows)), 4'($urandom),
                             4'($urandom_range(0, cols)), $signed($urandom));
    if (k < 52) return item(mrv_pkg::KIND_SWAP, 4'($urandom_range(0, rows)),
                             4'($urandom_range(0, rows)), 4'($urandom), $signed($urandom));
    if (k < 60) return item(mrv_pkg::KIND_SCALE_ROW, 4'($urandom_range(0, rows)),
                             4'($urandom), 4'($urandom), rnd_val());
    if (k < 72) return item(mrv_pkg::KIND_ADD_ROW, 4'($urandom_range(0, rows)),
                             4'($urandom_range(0, rows)), 4'($urandom),
                             ($urandom_range(0, 7) == 0) ? 32'sd0 : rnd_val());
    if (k < 76) return item(mrv_pkg::KIND_SCALE_ALL, 4'($urandom), 4'($urandom),
                             4'($urandom), rnd_val());
    if (k < 78) return item(mrv_pkg::KIND_FILL, 4'($urandom), 4'($urandom), 4'($urandom),
                             rnd_val());
    if (k < 95) return item(mrv_pkg::KIND_MULTIPLY, 4'($urandom), 4'($urandom),
                             4'($urandom), $signed($urandom));
    return item(4'($urandom_range(9, 15)), 4'($urandom), 4'($urandom), 4'($urandom),
                $signed($urandom));
  endfunction

  typedef struct {
    mrv_pkg::in_item_t   it;
    bit                  typed;
    mrv_pkg::out_item_t  res;
  } dir_row_t;

  dir_row_t dir_tab [$];

  initial begin
    int guard, rows, cols;
    mrv_pkg::in_item_t it;
    errors = 0;
    hold_off = 0;
    foreach (mat_q[i]) mat_q[i] = 0;
    foreach (vec_q[i]) vec_q[i] = 0;
    rows_raw = 5'(mrv_pkg::COUNT_RESET);
    cols_raw = 5'(mrv_pkg::COUNT_RESET);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      '{item(mrv_pkg::KIND_READ, 15, 0, 15, 0), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_WRITE, 0, 0, 0, 32'sh7fffffff), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_READ, 0, 0, 0, 0), 1, mk(32'sh7fffffff, 0, 0, 1)},
      '{item(mrv_pkg::KIND_WRITE, 15, 15, 15, 32'sh80000000), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_READ, 15, 15, 15, 0), 1, mk(32'sh80000000, 0, 0, 1)},
      '{item(mrv_pkg::KIND_LOAD_VEC, 0, 0, 0, 32'sh00010000), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_LOAD_VEC, 0, 0, 15, 32'sh80000000), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_MULTIPLY, 0, 0, 0, 0), 0, mk(0, 0, 0, 0)},
      '{item(mrv_pkg::KIND_SWAP, 0, 15, 0, 0), 0, mk(0, 0, 0, 0)},
      '{item(mrv_pkg::KIND_SWAP, 3, 3, 0, 0), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_SCALE_ROW, 15, 0, 0, 32'sh00020000), 0, mk(0, 0, 0, 0)},
      '{item(mrv_pkg::KIND_ADD_ROW, 15, 0, 0, 32'sh00008000), 0, mk(0, 0, 0, 0)},
      '{item(mrv_pkg::KIND_ADD_ROW, 0, 0, 0, 32'shffff0000), 0, mk(0, 0, 0, 0)},
      '{item(mrv_pkg::KIND_ADD_ROW, 1, 2, 0, 0), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_SCALE_ROW, 0, 0, 0, 0), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_FILL, 0, 0, 0, 32'shfffe8000), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_SCALE_ALL, 0, 0, 0, 32'sh7fffffff), 1, mk(0, 0, 0, 1)},
      '{item(mrv_pkg::KIND_MULTIPLY, 0, 0, 0, 0), 0, mk(0, 0, 0, 0)},
      '{item(4'd9, 4'hf, 4'hf, 4'hf, 32'shffffffff), 1, mk(0, 0, 0, 1)},
      '{item(4'd15, 0, 0, 0, 0), 1, mk(0, 0, 0, 1)}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed) begin
        send(dir_tab[i].it);
        void'(pending_results.pop_back());
        queue_result(dir_tab[i].res);
      end else send(dir_tab[i].it);
    end

    // small sizes, out-of-range indexes give errors
    set_count(mrv_pkg::CFG_ROW_COUNT, 5'd3);
    set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'd2);
    send(item(mrv_pkg::KIND_WRITE, 3, 0, 0, 1));
    void'(pending_results.pop_back());
    queue_result(mk(0, 0, 1, 1));
    send(item(mrv_pkg::KIND_READ, 0, 0, 2, 0));
    void'(pending_results.pop_back());
    queue_result(mk(0, 0, 1, 1));
    send(item(mrv_pkg::KIND_LOAD_VEC, 0, 0, 2, 1));
    void'(pending_results.pop_back());
    queue_result(mk(0, 0, 1, 1));
    send(item(mrv_pkg::KIND_SWAP, 0, 7, 0, 0));
    void'(pending_results.pop_back());
    queue_result(mk(0, 0, 1, 1));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_count(mrv_pkg::CFG_ROW_COUNT, 5'd0);
          set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'd0);
        end
        1: begin
          set_count(mrv_pkg::CFG_ROW_COUNT, 5'd31);
          set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'd17);
        end
        2: begin
          set_count(mrv_pkg::CFG_ROW_COUNT, 5'd16);
          set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'd16);
        end
        3: begin
          set_count(mrv_pkg::CFG_ROW_COUNT, 5'd1);
          set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'd16);
        end
        default: begin
          set_count(mrv_pkg::CFG_ROW_COUNT, 5'($urandom_range(2, 8)));
          set_count(mrv_pkg::CFG_COLUMN_COUNT, 5'($urandom_range(2, 8)));
        end
      endcase
      rows = eff(rows_raw, NR);
      cols = eff(cols_raw, NC);
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 50; n++) begin
        it = rnd_item(rows > 15 ? 15 : rows, cols > 15 ? 15 : cols);
        send(it);
      end
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 500000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
